>>> hw/rtl/imh_pkg.sv
// Shared constants for the indexed max-heap block.
// No dependencies; the channel interfaces and the core module import this package.
package imh_pkg;

  // Fixed field widths of the request, response and configuration channels.
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned CNT_W   = 11;

  // Request operation codes. The spare code is accepted and changes nothing.
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXTRACT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;

  // Count after reset.
  localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

endpackage

>>> hw/rtl/imh_req_if.sv
// Request channel of the indexed max-heap block.
// Depends on imh_pkg for the field widths.
interface imh_req_if import imh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [POS_W-1:0]   position;
  logic [SCORE_W-1:0] score_value;
  logic               load_last;

  modport source (output valid, kind, position, score_value, load_last, input ready);
  modport sink   (input valid, kind, position, score_value, load_last, output ready);
endinterface

>>> hw/rtl/imh_rsp_if.sv
// Response channel of the indexed max-heap block.
// Depends on imh_pkg for the field widths.
interface imh_rsp_if import imh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] top_position;
  logic             top_valid;
  logic [CNT_W-1:0] live_count;

  modport source (output valid, top_position, top_valid, live_count, input ready);
  modport sink   (input valid, top_position, top_valid, live_count, output ready);
endinterface

>>> hw/rtl/imh_cfg_if.sv
// Configuration write channel of the indexed max-heap block.
// Depends on imh_pkg for the register width.
interface imh_cfg_if import imh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/imh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module imh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hw/rtl/indexed_max_heap_core.sv
// Indexed binary max-heap over positions keyed by score.
// Depends on imh_pkg, the imh_*_if channel interfaces and imh_ram.
//
// Usage: the request channel carries load, update and extract requests;
// every request yields exactly one response holding the removed top position
// (extract only), its valid flag and the live heap size. The configuration
// channel writes entry_count and is always ready; write it only while idle.
// Scores are loaded with load requests; a load with load_last set rebuilds
// the heap from all scores below the count.
// Flow: one request is worked on at a time and is taken only in the idle
// state. A plain load once a heap exists also refreshes the score copy in
// the heap slot of its position, if that position sits in the heap.
// Sift-down reads the left and then the right child through the one read
// port of the heap memory. An update that moved the entry up sifts its old
// slot down again afterwards. A build sweeps all CAPACITY entries, one per
// cycle, and then sifts down from count/2-1 to 0.
// After reset the heap is empty and the count is 1024; no clearing pass runs.
// A stalled response is held in the output register; the next request is
// taken meanwhile, and its result waits until the register frees.
module indexed_max_heap_core import imh_pkg::*; #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned SCORE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  imh_req_if.sink     req_i,
  imh_rsp_if.source   rsp_o,
  imh_cfg_if.sink     cfg_i
);

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned SW  = $clog2(CAPACITY + 1);
  localparam int unsigned XW  = AW + 2;
  localparam int unsigned SB  = SCORE_BITS;
  localparam int unsigned HW  = AW + SB;
  localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_SWEEP    = 14'b00000000000010,
    ST_BLD_NEXT = 14'b00000000000100,
    ST_DN_LOAD  = 14'b00000000001000,
    ST_DN_ISSUE = 14'b00000000010000,
    ST_DN_L     = 14'b00000000100000,
    ST_DN_R     = 14'b00000001000000,
    ST_DN_DEC   = 14'b00000010000000,
    ST_UPD_SLOT = 14'b00000100000000,
    ST_UP_ISSUE = 14'b00001000000000,
    ST_UP_CMP   = 14'b00010000000000,
    ST_EX_TOP   = 14'b00100000000000,
    ST_DONE     = 14'b01000000000000,
    ST_LD_SLOT  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] ec_q, ec_d;
  logic [SW-1:0]    fill_q, fill_d;
  logic [AW-1:0]    s_q, s_d;
  logic [AW-1:0]    org_q, org_d;
  logic [AW-1:0]    e_pos_q, e_pos_d;
  logic [SB-1:0]    e_sc_q, e_sc_d;
  logic [AW-1:0]    l_pos_q, l_pos_d, r_pos_q, r_pos_d;
  logic [SB-1:0]    l_sc_q, l_sc_d, r_sc_q, r_sc_d;
  logic             have_r_q, have_r_d;
  logic             moved_q, moved_d;
  logic             build_q, build_d;
  logic [SW-1:0]    bld_q, bld_d;
  logic [AW-1:0]    top_q, top_d;
  logic             topv_q, topv_d;
  logic [SW-1:0]    swp_rd_q, swp_rd_d;
  logic [AW-1:0]    swp_wr_q, swp_wr_d;
  logic             swp_pend_q, swp_pend_d;
  logic             rsp_v_q, rsp_v_d;
  logic [POS_W-1:0] rsp_pos_q, rsp_pos_d;
  logic             rsp_tv_q, rsp_tv_d;
  logic [CNT_W-1:0] rsp_cnt_q, rsp_cnt_d;

  // Memory ports.
  logic          h_we, h_re;
  logic [AW-1:0] h_wa, h_ra;
  logic [HW-1:0] h_wd, h_rd;
  logic          p_we, p_re;
  logic [AW-1:0] p_wa, p_ra;
  logic [SW-1:0] p_wd, p_rd;
  logic          c_we, c_re;
  logic [AW-1:0] c_wa, c_ra;
  logic [SB-1:0] c_wd, c_rd;

  // Heap slots hold {position, score}; the score copy saves a second lookup.
  imh_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd),
    .re_i(h_re), .raddr_i(h_ra), .rdata_o(h_rd)
  );

  // Slot of each position.
  imh_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slot_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd),
    .re_i(p_re), .raddr_i(p_ra), .rdata_o(p_rd)
  );

  // Score of each position.
  imh_ram #(.WIDTH(SB), .DEPTH(CAPACITY)) u_score_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd),
    .re_i(c_re), .raddr_i(c_ra), .rdata_o(c_rd)
  );

  // Request fields brought to internal widths.
  logic [31:0]   pos_w;
  logic [63:0]   sc_w;
  logic [AW-1:0] pos_a;
  logic [SB-1:0] sc_in;
  logic [SW-1:0] live_n;
  assign pos_w = 32'(req_i.position);
  assign sc_w  = 64'(req_i.score_value);
  assign pos_a = pos_w[AW-1:0];
  assign sc_in = sc_w[SB-1:0];
  assign live_n = (32'(ec_q) > CAPACITY) ? CAP_S : SW'(ec_q);

  // Child and parent indexes of the current slot.
  logic [XW-1:0] l_x, r_x, fill_x;
  logic [AW-1:0] par_a;
  assign l_x    = {1'b0, s_q, 1'b1};
  assign r_x    = l_x + XW'(1);
  assign fill_x = XW'(fill_q);
  assign par_a  = (s_q - AW'(1)) >> 1;

  // Sift-down choice: the left child wins a tie between children.
  logic          dn_bl, dn_br, dn_move;
  logic [SB-1:0] dn_bsc;
  assign dn_bl   = l_sc_q > e_sc_q;
  assign dn_bsc  = dn_bl ? l_sc_q : e_sc_q;
  assign dn_br   = have_r_q && (r_sc_q > dn_bsc);
  assign dn_move = dn_bl || dn_br;

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid        = rsp_v_q;
  assign rsp_o.top_position = rsp_pos_q;
  assign rsp_o.top_valid    = rsp_tv_q;
  assign rsp_o.live_count   = rsp_cnt_q;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    ec_d       = ec_q;
    fill_d     = fill_q;
    s_d        = s_q;
    org_d      = org_q;
    e_pos_d    = e_pos_q;
    e_sc_d     = e_sc_q;
    l_pos_d    = l_pos_q;
    l_sc_d     = l_sc_q;
    r_pos_d    = r_pos_q;
    r_sc_d     = r_sc_q;
    have_r_d   = have_r_q;
    moved_d    = moved_q;
    build_d    = build_q;
    bld_d      = bld_q;
    top_d      = top_q;
    topv_d     = topv_q;
    swp_rd_d   = swp_rd_q;
    swp_wr_d   = swp_wr_q;
    swp_pend_d = swp_pend_q;
    rsp_v_d    = rsp_v_q;
    rsp_pos_d  = rsp_pos_q;
    rsp_tv_d   = rsp_tv_q;
    rsp_cnt_d  = rsp_cnt_q;

    h_we = 1'b0; h_wa = s_q; h_wd = {e_pos_q, e_sc_q};
    h_re = 1'b0; h_ra = s_q;
    p_we = 1'b0; p_wa = e_pos_q; p_wd = SW'(s_q);
    p_re = 1'b0; p_ra = pos_a;
    c_we = 1'b0; c_wa = pos_a; c_wd = sc_in;
    c_re = 1'b0; c_ra = swp_rd_q[AW-1:0];

    // Response register drains independently of the sequencer.
    if (rsp_v_q && rsp_o.ready) begin
      rsp_v_d = 1'b0;
    end

    if (cfg_i.valid) begin
      ec_d = cfg_i.data;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          top_d   = '0;
          topv_d  = 1'b0;
          build_d = 1'b0;
          moved_d = 1'b0;
          state_d = ST_DONE;
          case (req_i.kind)
            KIND_LOAD: begin
              c_we = (pos_w < CAPACITY);
              if (req_i.load_last) begin
                build_d    = 1'b1;
                swp_rd_d   = '0;
                swp_pend_d = 1'b0;
                state_d    = ST_SWEEP;
              end else if (fill_q != '0) begin
                // A position in the heap also needs its slot's score copy.
                p_re    = 1'b1;
                e_pos_d = pos_a;
                e_sc_d  = sc_in;
                state_d = ST_LD_SLOT;
              end
            end
            KIND_UPDATE: begin
              if (pos_w < 32'(live_n)) begin
                c_we    = 1'b1;
                p_re    = 1'b1;
                e_pos_d = pos_a;
                e_sc_d  = sc_in;
                state_d = ST_UPD_SLOT;
              end
            end
            KIND_EXTRACT: begin
              if (fill_q != '0) begin
                h_re    = 1'b1;
                h_ra    = '0;
                state_d = ST_EX_TOP;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // Refresh the score copy of a loaded position that sits in the heap.
      ST_LD_SLOT: begin
        if (p_rd < fill_q) begin
          h_we = 1'b1;
          h_wa = p_rd[AW-1:0];
        end
        state_d = ST_DONE;
      end

      // Copy every score into slot order and set the slot map.
      ST_SWEEP: begin
        if (swp_rd_q < CAP_S) begin
          c_re       = 1'b1;
          swp_wr_d   = swp_rd_q[AW-1:0];
          swp_rd_d   = swp_rd_q + SW'(1);
          swp_pend_d = 1'b1;
        end else begin
          swp_pend_d = 1'b0;
        end
        if (swp_pend_q) begin
          h_we = 1'b1;
          h_wa = swp_wr_q;
          h_wd = {swp_wr_q, c_rd};
          p_we = 1'b1;
          p_wa = swp_wr_q;
          p_wd = (SW'(swp_wr_q) < live_n) ? SW'(swp_wr_q) : CAP_S;
          if (swp_wr_q == LAST_A) begin
            fill_d  = live_n;
            bld_d   = live_n >> 1;
            state_d = ST_BLD_NEXT;
          end
        end
      end

      ST_BLD_NEXT: begin
        if (bld_q == '0) begin
          state_d = ST_DONE;
        end else begin
          s_d     = AW'(bld_q - SW'(1));
          h_re    = 1'b1;
          h_ra    = AW'(bld_q - SW'(1));
          bld_d   = bld_q - SW'(1);
          state_d = ST_DN_LOAD;
        end
      end

      ST_DN_LOAD: begin
        e_pos_d = h_rd[HW-1:SB];
        e_sc_d  = h_rd[SB-1:0];
        state_d = ST_DN_ISSUE;
      end

      ST_DN_ISSUE: begin
        if (l_x < fill_x) begin
          h_re    = 1'b1;
          h_ra    = l_x[AW-1:0];
          state_d = ST_DN_L;
        end else begin
          // No children: the hole takes the entry.
          h_we    = 1'b1;
          p_we    = 1'b1;
          state_d = build_q ? ST_BLD_NEXT : ST_DONE;
        end
      end

      ST_DN_L: begin
        l_pos_d = h_rd[HW-1:SB];
        l_sc_d  = h_rd[SB-1:0];
        if (r_x < fill_x) begin
          h_re    = 1'b1;
          h_ra    = r_x[AW-1:0];
          state_d = ST_DN_R;
        end else begin
          have_r_d = 1'b0;
          state_d  = ST_DN_DEC;
        end
      end

      ST_DN_R: begin
        r_pos_d  = h_rd[HW-1:SB];
        r_sc_d   = h_rd[SB-1:0];
        have_r_d = 1'b1;
        state_d  = ST_DN_DEC;
      end

      // Move the larger child up into the hole, or settle the entry.
      ST_DN_DEC: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (dn_move) begin
          h_wd    = dn_br ? {r_pos_q, r_sc_q} : {l_pos_q, l_sc_q};
          p_wa    = dn_br ? r_pos_q : l_pos_q;
          s_d     = dn_br ? r_x[AW-1:0] : l_x[AW-1:0];
          state_d = ST_DN_ISSUE;
        end else begin
          state_d = build_q ? ST_BLD_NEXT : ST_DONE;
        end
      end

      ST_UPD_SLOT: begin
        if (p_rd < fill_q) begin
          s_d     = p_rd[AW-1:0];
          org_d   = p_rd[AW-1:0];
          state_d = ST_UP_ISSUE;
        end else begin
          state_d = ST_DONE;
        end
      end

      // At the root the sift-up ends. A moved entry settles here and the
      // original slot is sifted down; otherwise the entry goes on down.
      ST_UP_ISSUE: begin
        if (s_q == '0) begin
          if (moved_q) begin
            h_we    = 1'b1;
            p_we    = 1'b1;
            h_re    = 1'b1;
            h_ra    = org_q;
            s_d     = org_q;
            state_d = ST_DN_LOAD;
          end else begin
            state_d = ST_DN_ISSUE;
          end
        end else begin
          h_re    = 1'b1;
          h_ra    = par_a;
          state_d = ST_UP_CMP;
        end
      end

      // Sift-up stops on an equal score. If the entry never moved it goes on
      // down from the same slot; after a move it settles and the original
      // slot, now holding the old parent, is sifted down.
      ST_UP_CMP: begin
        if (e_sc_q <= h_rd[SB-1:0]) begin
          if (moved_q) begin
            h_we    = 1'b1;
            p_we    = 1'b1;
            h_re    = 1'b1;
            h_ra    = org_q;
            s_d     = org_q;
            state_d = ST_DN_LOAD;
          end else begin
            state_d = ST_DN_ISSUE;
          end
        end else begin
          h_we    = 1'b1;
          h_wd    = h_rd;
          p_we    = 1'b1;
          p_wa    = h_rd[HW-1:SB];
          s_d     = par_a;
          moved_d = 1'b1;
          state_d = ST_UP_ISSUE;
        end
      end

      // Take the top, mark it absent, and move the last entry to the root.
      ST_EX_TOP: begin
        top_d  = h_rd[HW-1:SB];
        topv_d = 1'b1;
        fill_d = fill_q - SW'(1);
        p_we   = 1'b1;
        p_wa   = h_rd[HW-1:SB];
        p_wd   = CAP_S;
        if (fill_q == SW'(1)) begin
          state_d = ST_DONE;
        end else begin
          h_re    = 1'b1;
          h_ra    = AW'(fill_q - SW'(1));
          s_d     = '0;
          state_d = ST_DN_LOAD;
        end
      end

      ST_DONE: begin
        if (!rsp_v_q || rsp_o.ready) begin
          rsp_v_d   = 1'b1;
          rsp_pos_d = POS_W'(top_q);
          rsp_tv_d  = topv_q;
          rsp_cnt_d = CNT_W'(fill_q);
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ec_q       <= ENTRY_COUNT_RESET;
      fill_q     <= '0;
      build_q    <= 1'b0;
      moved_q    <= 1'b0;
      swp_pend_q <= 1'b0;
      rsp_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      ec_q       <= ec_d;
      fill_q     <= fill_d;
      build_q    <= build_d;
      moved_q    <= moved_d;
      swp_pend_q <= swp_pend_d;
      rsp_v_q    <= rsp_v_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    s_q       <= s_d;
    org_q     <= org_d;
    e_pos_q   <= e_pos_d;
    e_sc_q    <= e_sc_d;
    l_pos_q   <= l_pos_d;
    l_sc_q    <= l_sc_d;
    r_pos_q   <= r_pos_d;
    r_sc_q    <= r_sc_d;
    have_r_q  <= have_r_d;
    bld_q     <= bld_d;
    top_q     <= top_d;
    topv_q    <= topv_d;
    swp_rd_q  <= swp_rd_d;
    swp_wr_q  <= swp_wr_d;
    rsp_pos_q <= rsp_pos_d;
    rsp_tv_q  <= rsp_tv_d;
    rsp_cnt_q <= rsp_cnt_d;
  end

endmodule
